>>> design/button_debounce_double_press_defines.svh
// Assertion macros for the button debouncer with double-press detection.
`ifndef BUTTON_DEBOUNCE_DOUBLE_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_DOUBLE_PRESS_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BDD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bdd_pkg.sv
// Shared types, constants and helpers for the button debouncer.
`default_nettype none
package bdd_pkg;

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned HOLD_W  = 32;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [TICK_W-1:0]  SETTLE_RESET = 16'd60;
    localparam logic [TICK_W-1:0]  WINDOW_RESET = 16'd300;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 7'd127;

    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 1'd1;

    typedef struct packed {
        logic               press_pulse;
        logic               second_press_pulse;
        logic               release_pulse;
        logic [COUNT_W-1:0] press_total;
        logic [HOLD_W-1:0]  held_ticks;
    } t_result;

    function automatic logic [TICK_W-1:0] f_inc_sat16(input logic [TICK_W-1:0] v);
        return (v == {TICK_W{1'b1}}) ? v : v + 16'd1;
    endfunction

endpackage
`default_nettype wire

>>> design/bdd_core.sv
// Debounce phase machine, timers and press counter; one tick per step.
`default_nettype none
module bdd_core import bdd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic              i_level,
    input  wire logic [TICK_W-1:0] i_settle_ticks,
    input  wire logic [TICK_W-1:0] i_window_ticks,
    output t_result                o_result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_HELD,
        PH_RELEASE
    } t_phase;

    t_phase             r_phase,           n_phase;
    logic [TICK_W-1:0]  r_settle_elapsed,  n_settle_elapsed;
    logic [TICK_W-1:0]  r_release_elapsed, n_release_elapsed;
    logic [TICK_W-1:0]  r_window_elapsed,  n_window_elapsed;
    logic               r_window_running,  n_window_running;
    logic [COUNT_W-1:0] r_press_counter,   n_press_counter;
    logic [HOLD_W-1:0]  r_hold_counter,    n_hold_counter;
    logic               n_press, n_second, n_release;

    always_comb begin
        n_phase           = r_phase;
        n_settle_elapsed  = r_settle_elapsed;
        n_release_elapsed = r_release_elapsed;
        n_window_elapsed  = r_window_elapsed;
        n_window_running  = r_window_running;
        n_press_counter   = r_press_counter;
        n_hold_counter    = r_hold_counter;
        n_press           = 1'b0;
        n_second          = 1'b0;
        n_release         = 1'b0;

        // running timers advance first
        if (r_phase == PH_SETTLE) begin
            n_settle_elapsed = f_inc_sat16(r_settle_elapsed);
        end
        if (r_phase == PH_RELEASE) begin
            n_release_elapsed = f_inc_sat16(r_release_elapsed);
        end
        if (r_window_running) begin
            n_window_elapsed = f_inc_sat16(r_window_elapsed);
        end
        if (r_phase == PH_HELD && r_hold_counter != {HOLD_W{1'b1}}) begin
            n_hold_counter = r_hold_counter + 32'd1;
        end

        if (i_level) begin
            if (r_phase == PH_IDLE) begin
                n_phase          = PH_SETTLE;
                n_settle_elapsed = '0;
            end else if (r_phase == PH_SETTLE && n_settle_elapsed >= i_settle_ticks) begin
                n_phase        = PH_HELD;
                n_hold_counter = '0;
                if (r_press_counter != COUNT_MAX) begin
                    n_press_counter = r_press_counter + 7'd1;
                end
                n_press  = 1'b1;
                n_second = (n_press_counter != 7'd1);
            end
        end else begin
            if (r_phase == PH_HELD) begin
                n_phase           = PH_RELEASE;
                n_release_elapsed = '0;
            end else if (r_phase == PH_RELEASE && n_release_elapsed >= i_settle_ticks) begin
                n_window_running = 1'b1;
                n_window_elapsed = '0;
                n_release        = 1'b1;
                n_phase          = PH_IDLE;
            end
            // expired window: a low sample ends the run
            if (n_window_running && n_window_elapsed >= i_window_ticks) begin
                n_press_counter  = '0;
                n_window_running = 1'b0;
            end
        end

        o_result.press_pulse        = n_press;
        o_result.second_press_pulse = n_second;
        o_result.release_pulse      = n_release;
        o_result.press_total        = n_press_counter;
        o_result.held_ticks         = (n_phase == PH_HELD) ? n_hold_counter : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_settle_elapsed  <= '0;
            r_release_elapsed <= '0;
            r_window_elapsed  <= '0;
            r_window_running  <= 1'b0;
            r_press_counter   <= '0;
            r_hold_counter    <= '0;
        end else if (i_step) begin
            r_phase           <= n_phase;
            r_settle_elapsed  <= n_settle_elapsed;
            r_release_elapsed <= n_release_elapsed;
            r_window_elapsed  <= n_window_elapsed;
            r_window_running  <= n_window_running;
            r_press_counter   <= n_press_counter;
            r_hold_counter    <= n_hold_counter;
        end
    end

endmodule
`default_nettype wire

>>> design/button_debounce_double_press.sv
// Button debouncer with double-press detection: top level.
// One input transfer per millisecond tick carrying the sampled pin level; each
// tick gives exactly one result transfer with press, second-press and release
// pulses, the saturating press count and the held time. A tick passes through
// an input register and the phase machine into a result register; a stall on
// the result side can hold a tick in the input register before it is stepped.
// A new tick is taken every cycle, and only a stall on the result side holds the
// input back. The settle time and repeat window registers reset to 60 and 300
// ticks and are written through the always-ready configuration port; the user
// must write them only while no tick is in flight, the block does not enforce it.
`default_nettype none
`include "button_debounce_double_press_defines.svh"
module button_debounce_double_press import bdd_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_pin_level,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_press_pulse,
    output logic                      o_second_press_pulse,
    output logic                      o_release_pulse,
    output logic [COUNT_W-1:0]        o_press_total,
    output logic [HOLD_W-1:0]         o_held_ticks,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [TICK_W-1:0]    i_cfg_data
);

    logic              r_in_valid;
    logic              r_in_level;
    logic              r_out_valid;
    t_result           r_out;
    logic [TICK_W-1:0] r_settle_ticks;
    logic [TICK_W-1:0] r_window_ticks;
    logic              w_out_free;
    logic              w_step;
    t_result           w_result;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign o_cfg_ready = 1'b1;

    bdd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_level        (r_in_level),
        .i_settle_ticks (r_settle_ticks),
        .i_window_ticks (r_window_ticks),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_settle_ticks <= SETTLE_RESET;
            r_window_ticks <= WINDOW_RESET;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SETTLE_TICKS: r_settle_ticks <= i_cfg_data;
                    CFG_WINDOW_TICKS: r_window_ticks <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_level <= i_pin_level;
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_press_pulse        = r_out.press_pulse;
    assign o_second_press_pulse = r_out.second_press_pulse;
    assign o_release_pulse      = r_out.release_pulse;
    assign o_press_total        = r_out.press_total;
    assign o_held_ticks         = r_out.held_ticks;

    `BDD_ASSERT_NOW(a_second_needs_press, r_out_valid && r_out.second_press_pulse, r_out.press_pulse, "second press without press")
    `BDD_ASSERT_NOW(a_press_release_apart, r_out_valid, !(r_out.press_pulse && r_out.release_pulse), "press and release on one tick")
    `BDD_ASSERT_NOW(a_press_counted, r_out_valid && r_out.press_pulse, r_out.press_total != '0, "confirmed press not counted")
    `BDD_ASSERT_NEXT(a_step_fills_output, w_step, r_out_valid, "stepped tick left no result")

endmodule
`default_nettype wire

>>> tb/sv/button_debounce_double_press_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the button debouncer with double-press detection.
module button_debounce_double_press_tb;
    import bdd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_TICKS = 820;
    localparam int unsigned QUIET_TAIL   = 200;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned MAX_REPORTS  = 100;
    localparam int unsigned SETTLE_PROBE = 60;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SETTLING,
        PH_HELD,
        PH_RELEASING
    } t_phase;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_pin_level = 1'b0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_SETTLE_TICKS;
    logic [TICK_W-1:0]    i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_press_pulse;
    logic                 o_second_press_pulse;
    logic                 o_release_pulse;
    logic [COUNT_W-1:0]   o_press_total;
    logic [HOLD_W-1:0]    o_held_ticks;
    logic                 o_cfg_ready;

    button_debounce_double_press uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_pin_level          (i_pin_level),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_press_pulse        (o_press_pulse),
        .o_second_press_pulse (o_second_press_pulse),
        .o_release_pulse      (o_release_pulse),
        .o_press_total        (o_press_total),
        .o_held_ticks         (o_held_ticks),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // debouncer state as predicted
    t_phase             btn_phase   = PH_IDLE;
    logic [TICK_W-1:0]  settle_age  = '0;
    logic [TICK_W-1:0]  release_age = '0;
    logic [TICK_W-1:0]  window_age  = '0;
    logic               window_on   = 1'b0;
    logic [COUNT_W-1:0] press_count = '0;
    logic [HOLD_W-1:0]  hold_age    = '0;
    logic [TICK_W-1:0]  cfg_settle  = SETTLE_RESET;
    logic [TICK_W-1:0]  cfg_window  = WINDOW_RESET;

    t_result     button_results_q[$];
    int unsigned ticks_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned cfg_writes      = 0;
    int unsigned fail_count      = 0;
    int unsigned cycle_count     = 0;
    bit          quiet           = 1'b0;

    function automatic logic [TICK_W-1:0] sat_tick(input logic [TICK_W-1:0] a);
        return (a == '1) ? a : a + 1'b1;
    endfunction

    function void debounce_tick(input logic lvl);
        t_result r;
        r = '0;
        if (btn_phase == PH_SETTLING) settle_age = sat_tick(settle_age);
        if (btn_phase == PH_RELEASING) release_age = sat_tick(release_age);
        if (window_on) window_age = sat_tick(window_age);
        if (btn_phase == PH_HELD && hold_age != '1) hold_age = hold_age + 1'b1;
        if (lvl) begin
            if (btn_phase == PH_IDLE) begin
                btn_phase  = PH_SETTLING;
                settle_age = '0;
            end else if (btn_phase == PH_SETTLING && settle_age >= cfg_settle) begin
                btn_phase = PH_HELD;
                hold_age  = '0;
                if (press_count < COUNT_MAX) press_count = press_count + 1'b1;
                r.press_pulse        = 1'b1;
                r.second_press_pulse = (press_count != 7'd1);
            end
        end else begin
            if (btn_phase == PH_HELD) begin
                btn_phase   = PH_RELEASING;
                release_age = '0;
            end else if (btn_phase == PH_RELEASING && release_age >= cfg_settle) begin
                window_on       = 1'b1;
                window_age      = '0;
                r.release_pulse = 1'b1;
                btn_phase       = PH_IDLE;
            end
            if (window_on && window_age >= cfg_window) begin
                press_count = '0;
                window_on   = 1'b0;
            end
        end
        r.press_total = press_count;
        r.held_ticks  = (btn_phase == PH_HELD) ? hold_age : '0;
        button_results_q.push_back(r);
    endfunction

    task automatic report_field(input string name, input logic [HOLD_W-1:0] want,
                                input logic [HOLD_W-1:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (button_results_q.size() == 0) begin
                fail_count++;
                $display("%0t: result transfer with nothing expected, expected none, actual %h",
                         $time, {o_press_pulse, o_second_press_pulse, o_release_pulse,
                                 o_press_total, o_held_ticks});
            end else begin
                want = button_results_q.pop_front();
                results_checked++;
                if (want.press_pulse !== o_press_pulse)
                    report_field("press_pulse", HOLD_W'(want.press_pulse),
                                 HOLD_W'(o_press_pulse));
                if (want.second_press_pulse !== o_second_press_pulse)
                    report_field("second_press_pulse", HOLD_W'(want.second_press_pulse),
                                 HOLD_W'(o_second_press_pulse));
                if (want.release_pulse !== o_release_pulse)
                    report_field("release_pulse", HOLD_W'(want.release_pulse),
                                 HOLD_W'(o_release_pulse));
                if (want.press_total !== o_press_total)
                    report_field("press_total", HOLD_W'(want.press_total),
                                 HOLD_W'(o_press_total));
                if (want.held_ticks !== o_held_ticks)
                    report_field("held_ticks", want.held_ticks, o_held_ticks);
            end
        end
    end

    // receiver back-pressure in random bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles", cycle_count);
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_tick(input logic lvl);
        i_in_valid  <= 1'b1;
        i_pin_level <= lvl;
        do @(posedge i_clk); while (o_in_stall);
        debounce_tick(lvl);
        ticks_sent++;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (button_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SETTLE_TICKS) cfg_settle = val;
        else cfg_window = val;
        cfg_writes++;
    endtask

    task automatic set_timing(input logic [TICK_W-1:0] settle, input logic [TICK_W-1:0] window);
        write_cfg(CFG_SETTLE_TICKS, settle);
        write_cfg(CFG_WINDOW_TICKS, window);
    endtask

    // press, hold, release and a low gap; bounce is ignored by the settling timers
    task automatic press_sequence(input int hold_len, input int gap_len, input bit bouncy);
        send_tick(1'b1);
        repeat (cfg_settle) send_tick(!bouncy || $urandom_range(0, 3) != 0);
        send_tick(1'b1);
        repeat (hold_len) send_tick(1'b1);
        send_tick(1'b0);
        repeat (cfg_settle) send_tick(bouncy && $urandom_range(0, 3) == 0);
        send_tick(1'b0);
        repeat (gap_len) send_tick(1'b0);
    endtask

    task automatic test_bounce_and_double_press();
        set_timing(16'd2, 16'd3);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        repeat (4) send_tick(1'b0);
    endtask

    task automatic test_zero_timing();
        set_timing(16'd0, 16'd0);
        repeat (2) begin
            send_tick(1'b1);
            send_tick(1'b1);
            send_tick(1'b0);
            send_tick(1'b0);
        end
    endtask

    task automatic test_count_saturation();
        set_timing(16'd0, 16'hFFFF);
        repeat (130) press_sequence(0, 0, 1'b0);
    endtask

    task automatic test_long_settle();
        quiet = 1'b1;
        set_timing(16'hFFFF, 16'd0);
        send_tick(1'b1);
        repeat (SETTLE_PROBE) send_tick(1'($urandom_range(0, 1)));
        repeat (4) send_tick(1'b1);
        write_cfg(CFG_SETTLE_TICKS, 16'd0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        quiet = 1'b0;
    endtask

    task automatic test_random_sessions();
        int unsigned first_tick;
        int          n_seq;
        int          gap;
        bit          reset_timing_done;
        first_tick = ticks_sent;
        reset_timing_done = 1'b0;
        while (ticks_sent - first_tick < RANDOM_TICKS) begin
            if (!reset_timing_done) begin
                set_timing(SETTLE_RESET, WINDOW_RESET);
                n_seq = 2;
                reset_timing_done = 1'b1;
            end else begin
                case ($urandom_range(0, 4))
                    0:       write_cfg(CFG_SETTLE_TICKS, 16'd0);
                    1:       write_cfg(CFG_SETTLE_TICKS, 16'd1);
                    2, 3:    write_cfg(CFG_SETTLE_TICKS, TICK_W'($urandom_range(2, 6)));
                    default: write_cfg(CFG_SETTLE_TICKS, TICK_W'($urandom_range(7, 20)));
                endcase
                write_cfg(CFG_WINDOW_TICKS,
                          TICK_W'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24)));
                n_seq = $urandom_range(4, 10);
            end
            repeat (n_seq) begin
                if (ticks_sent - first_tick < RANDOM_TICKS) begin
                    if (ticks_sent - first_tick >= RANDOM_TICKS - QUIET_TAIL) quiet = 1'b1;
                    if ($urandom_range(0, 99) < 85) begin
                        if ($urandom_range(0, 1) == 0) gap = $urandom_range(0, cfg_window);
                        else gap = cfg_window + $urandom_range(1, 6);
                        press_sequence($urandom_range(0, 6), gap, 1'($urandom_range(0, 1)));
                    end else if ($urandom_range(0, 1) == 0) begin
                        repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
                    end else begin
                        // a run of high samples, at most one past the settle time, then low samples
                        repeat ($urandom_range(1, cfg_settle + 1)) send_tick(1'b1);
                        repeat ($urandom_range(1, 4)) send_tick(1'b0);
                    end
                    if ($urandom_range(0, 5) == 0) drain_results();
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bounce_and_double_press();
        test_zero_timing();
        test_count_saturation();
        test_long_settle();
        test_random_sessions();

        drain_results();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d ticks, checked %0d results, %0d register writes, %0d mismatches",
                 ticks_sent, results_checked, cfg_writes, fail_count);
        $display("Covered bounce, double press, zero and full-scale timing, count saturation");
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule

>>> button_debounce_double_press.f
+incdir+design
design/bdd_pkg.sv
design/bdd_core.sv
design/button_debounce_double_press.sv
tb/sv/button_debounce_double_press_tb.sv
